// ===== rtl/cdsc_pkg.sv =====
// Shared types, constants and digit helpers for the clock display and set controller.
// Used by rtl/clock_display_and_set_controller.sv; depends on nothing.
`timescale 1ns / 1ps

package cdsc_pkg;

   localparam logic [11:0] YEAR_MIN  = 12'd1872;
   localparam logic [11:0] YEAR_MAX  = 12'd2131;
   localparam logic [11:0] EPOCH_YEAR = 12'd2000;
   localparam logic [3:0]  BLANK_DIGIT = 4'd10;
   localparam logic [7:0]  SEC_MAX   = 8'd59;
   localparam logic [7:0]  MIN_MAX   = 8'd59;
   localparam logic [7:0]  HOUR_MAX  = 8'd23;
   localparam logic [7:0]  DAY_MAX   = 8'd31;
   localparam logic [7:0]  MONTH_MAX = 8'd12;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_PREV = 2'd1,
      OP_NEXT = 2'd2,
      OP_LOAD = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      VIEW_CLOCK = 3'd0,
      VIEW_DATE  = 3'd1,
      VIEW_YEAR  = 3'd2,
      SET_HOUR   = 3'd3,
      SET_MINUTE = 3'd4,
      SET_DAY    = 3'd5,
      SET_MONTH  = 3'd6,
      SET_YEAR   = 3'd7
   } view_type;

   typedef struct packed {
      op_type             mode;
      logic               enc_a;
      logic               enc_b;
      logic [7:0]         rtc_seconds;
      logic [7:0]         rtc_minutes;
      logic [7:0]         rtc_hours;
      logic [7:0]         rtc_day_year;
      logic [7:0]         rtc_month;
      logic signed [7:0]  rtc_year_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]         tube_select;
      logic [3:0]         digit;
      logic               dot;
      logic               rtc_write;
      logic [7:0]         wr_seconds;
      logic [7:0]         wr_minutes;
      logic [7:0]         wr_hours;
      logic [7:0]         wr_day_year;
      logic [7:0]         wr_month;
      logic signed [7:0]  wr_year_offset;
   } rsp_type;

   // quotient by ten through reciprocal multiply, exact over the whole 7-bit input range 0..127
   function automatic logic [3:0] div10(input logic [6:0] v);
      logic [14:0] p;
      p = 15'(v) * 15'd205;
      return p[14:11];
   endfunction

   function automatic logic [7:0] bcd_enc(input logic [6:0] v);
      logic [3:0] q;
      logic [6:0] r;
      q = div10(v);
      r = v - 7'(q) * 7'd10;
      return {q, r[3:0]};
   endfunction

   function automatic logic [7:0] bcd_dec(input logic [7:0] b);
      return {4'b0, b[3:0]} + {1'b0, b[7:4], 3'b0} + {3'b0, b[7:4], 1'b0};
   endfunction

   // thousands, hundreds, tens, ones of a year in 1000..2999
   function automatic logic [15:0] year_digits(input logic [11:0] y);
      logic [3:0]  th;
      logic [3:0]  h;
      logic [3:0]  t;
      logic [6:0]  r2;
      logic [6:0]  o;
      logic [11:0] rem12;
      logic [9:0]  rem;
      th = (y >= EPOCH_YEAR) ? 4'd2 : 4'd1;
      rem12 = y - ((th == 4'd2) ? 12'd2000 : 12'd1000);
      rem = rem12[9:0];
      h = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem >= 10'(k * 100)) h = 4'(k);
      end
      r2 = 7'(rem - 10'(h) * 10'd100);
      t = div10(r2);
      o = r2 - 7'(t) * 7'd10;
      return {th, h, t, o[3:0]};
   endfunction

endpackage

// ===== rtl/clock_display_and_set_controller.sv =====
// Clock display and set controller top level: tube multiplexing, encoder set logic,
// clock chip byte decode and encode. Depends on rtl/cdsc_pkg.sv.
`timescale 1ns / 1ps

// Takes one request per cycle. A request passes an input register and is applied to the time,
// date and view state when it leaves that register; a tick request leaves its response in the
// output register at that same edge, and rsp_valid rises with it. View step and load requests
// give no response. The single result register sets the rate: a request waits only while a
// tick response is held and rsp_ready is low.
module clock_display_and_set_controller
   import cdsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_req_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   view_type    view_ff, view_in;
   logic [1:0]  tube_ff, tube_in;
   logic        last_a_ff, last_a_in;
   logic        last_b_ff, last_b_in;
   logic [4:0]  hours_ff, hours_in;
   logic [5:0]  minutes_ff, minutes_in;
   logic [5:0]  seconds_ff, seconds_in;
   logic [4:0]  day_ff, day_in;
   logic [3:0]  month_ff, month_in;
   logic [11:0] year_ff, year_in;

   logic        out_free, s1_fire, is_tick;
   logic        step_up, step_down, wr;
   logic        on, hm_a, dm_a, hm_b, dm_b, yr;
   logic [7:0]  hours_bcd, minutes_bcd, day_bcd, month_bcd;
   logic [15:0] ydig;
   logic [3:0]  dg;
   logic        dt;
   logic [7:0]  sec_dec, min_dec, hour_dec, day_dec, month_dec;
   logic [11:0] year_load, year_off;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_tick   = (s1_req_ff.mode == OP_TICK);
   assign s1_fire   = s1_valid_ff && (!is_tick || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign s1_valid_in  = req_valid ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (s1_fire && is_tick) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // display of the state as it stands before this request
   assign hours_bcd   = bcd_enc({2'b0, hours_ff});
   assign minutes_bcd = bcd_enc({1'b0, minutes_ff});
   assign day_bcd     = bcd_enc({2'b0, day_ff});
   assign month_bcd   = bcd_enc({3'b0, month_ff});
   assign ydig        = year_digits(year_ff);

   assign on   = !seconds_ff[0];
   assign hm_a = view_ff == VIEW_CLOCK || view_ff == SET_MINUTE || (view_ff == SET_HOUR && on);
   assign dm_a = view_ff == VIEW_DATE || view_ff == SET_MONTH || (view_ff == SET_DAY && on);
   assign hm_b = view_ff == VIEW_CLOCK || view_ff == SET_HOUR || (view_ff == SET_MINUTE && on);
   assign dm_b = view_ff == VIEW_DATE || view_ff == SET_DAY || (view_ff == SET_MONTH && on);
   assign yr   = view_ff == VIEW_YEAR || (view_ff == SET_YEAR && on);

   always_comb begin
      dg = BLANK_DIGIT;
      dt = 1'b0;
      unique case (tube_ff)
         2'd3: begin
            if (hm_a) dg = hours_bcd[7:4];
            else if (dm_a) dg = day_bcd[7:4];
            else if (yr) dg = ydig[15:12];
         end
         2'd2: begin
            if (hm_a) dg = hours_bcd[3:0];
            else if (dm_a) dg = day_bcd[3:0];
            else if (yr) dg = ydig[11:8];
         end
         2'd1: begin
            dt = ((view_ff == VIEW_CLOCK || view_ff == SET_HOUR || view_ff == SET_MINUTE)
                  && seconds_ff[0]) || view_ff == VIEW_DATE || view_ff == SET_DAY
                  || view_ff == SET_MONTH;
            if (hm_b) dg = minutes_bcd[7:4];
            else if (dm_b) dg = month_bcd[7:4];
            else if (yr) dg = ydig[7:4];
         end
         default: begin
            if (hm_b) dg = minutes_bcd[3:0];
            else if (dm_b) dg = month_bcd[3:0];
            else if (yr) dg = ydig[3:0];
         end
      endcase
   end

   // clock chip byte decode with saturation
   assign sec_dec   = bcd_dec(s1_req_ff.rtc_seconds);
   assign min_dec   = bcd_dec(s1_req_ff.rtc_minutes);
   assign hour_dec  = bcd_dec(s1_req_ff.rtc_hours);
   assign day_dec   = bcd_dec({2'b0, s1_req_ff.rtc_day_year[5:0]});
   assign month_dec = bcd_dec({3'b0, s1_req_ff.rtc_month[4:0]});
   assign year_load = EPOCH_YEAR + {10'b0, s1_req_ff.rtc_day_year[7:6]}
                      + {{4{s1_req_ff.rtc_year_offset[7]}}, s1_req_ff.rtc_year_offset};

   assign step_up   = last_a_ff && !s1_req_ff.enc_a && !s1_req_ff.enc_b && !last_b_ff;
   assign step_down = !last_a_ff && s1_req_ff.enc_a && !s1_req_ff.enc_b && !last_b_ff;

   always_comb begin
      view_in    = view_ff;
      tube_in    = tube_ff;
      last_a_in  = last_a_ff;
      last_b_in  = last_b_ff;
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      day_in     = day_ff;
      month_in   = month_ff;
      year_in    = year_ff;
      wr         = 1'b0;
      if (s1_fire) begin
         unique case (s1_req_ff.mode)
            OP_PREV: view_in = view_type'(view_ff - 3'd1);
            OP_NEXT: view_in = view_type'(view_ff + 3'd1);
            OP_LOAD: begin
               seconds_in = (sec_dec > SEC_MAX) ? SEC_MAX[5:0] : sec_dec[5:0];
               minutes_in = (min_dec > MIN_MAX) ? MIN_MAX[5:0] : min_dec[5:0];
               hours_in   = (hour_dec > HOUR_MAX) ? HOUR_MAX[4:0] : hour_dec[4:0];
               day_in     = (day_dec == 8'd0) ? 5'd1
                            : ((day_dec > DAY_MAX) ? DAY_MAX[4:0] : day_dec[4:0]);
               month_in   = (month_dec == 8'd0) ? 4'd1
                            : ((month_dec > MONTH_MAX) ? MONTH_MAX[3:0] : month_dec[3:0]);
               year_in    = year_load;
            end
            default: begin
               tube_in   = tube_ff + 2'd1;
               last_a_in = s1_req_ff.enc_a;
               last_b_in = s1_req_ff.enc_b;
               if (step_up || step_down) begin
                  wr = 1'b1;
                  unique case (view_ff)
                     SET_HOUR: begin
                        if (step_up) hours_in = (hours_ff == 5'd23) ? 5'd0 : hours_ff + 5'd1;
                        else hours_in = (hours_ff == 5'd0) ? 5'd23 : hours_ff - 5'd1;
                     end
                     SET_MINUTE: begin
                        if (step_up) minutes_in = (minutes_ff == 6'd59) ? 6'd0 : minutes_ff + 6'd1;
                        else minutes_in = (minutes_ff == 6'd0) ? 6'd59 : minutes_ff - 6'd1;
                        seconds_in = 6'd0;
                     end
                     SET_DAY: begin
                        if (step_up) day_in = (day_ff >= 5'd31) ? 5'd1 : day_ff + 5'd1;
                        else day_in = (day_ff <= 5'd1) ? 5'd31 : day_ff - 5'd1;
                     end
                     SET_MONTH: begin
                        if (step_up) month_in = (month_ff >= 4'd12) ? 4'd1 : month_ff + 4'd1;
                        else month_in = (month_ff <= 4'd1) ? 4'd12 : month_ff - 4'd1;
                     end
                     SET_YEAR: begin
                        if (step_up) begin
                           if (year_ff < YEAR_MAX) year_in = year_ff + 12'd1;
                        end else begin
                           if (year_ff > YEAR_MIN) year_in = year_ff - 12'd1;
                        end
                     end
                     default: wr = 1'b0;
                  endcase
               end
            end
         endcase
      end
   end

   assign year_off = year_in - {10'b0, year_in[1:0]} - EPOCH_YEAR;

   always_comb begin
      rsp_in = '0;
      rsp_in.tube_select = tube_ff;
      rsp_in.digit       = dg;
      rsp_in.dot         = dt;
      if (wr) begin
         rsp_in.rtc_write      = 1'b1;
         rsp_in.wr_seconds     = bcd_enc({1'b0, seconds_in});
         rsp_in.wr_minutes     = bcd_enc({1'b0, minutes_in});
         rsp_in.wr_hours       = bcd_enc({2'b0, hours_in});
         rsp_in.wr_day_year    = bcd_enc({2'b0, day_in}) | {year_in[1:0], 6'b0};
         rsp_in.wr_month       = bcd_enc({3'b0, month_in});
         rsp_in.wr_year_offset = year_off[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         view_ff      <= VIEW_CLOCK;
         tube_ff      <= 2'd0;
         last_a_ff    <= 1'b0;
         last_b_ff    <= 1'b0;
         hours_ff     <= 5'd13;
         minutes_ff   <= 6'd37;
         seconds_ff   <= 6'd0;
         day_ff       <= 5'd1;
         month_ff     <= 4'd1;
         year_ff      <= 12'd2012;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         view_ff      <= view_in;
         tube_ff      <= tube_in;
         last_a_ff    <= last_a_in;
         last_b_ff    <= last_b_in;
         hours_ff     <= hours_in;
         minutes_ff   <= minutes_in;
         seconds_ff   <= seconds_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= req_payload;
      end
      if (s1_fire && is_tick) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== tb/sv/tb_clock_display_and_set_controller.sv =====
// Self-checking testbench for the clock display and set controller: directed and random
// requests, a scoreboard class that predicts each tick response. Depends on rtl/cdsc_pkg.sv.
`timescale 1ns / 1ps

module tb_clock_display_and_set_controller;
   import cdsc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 225;

   class tick_scoreboard;
      view_type    view;
      logic [1:0]  tube;
      logic        last_a;
      logic        last_b;
      int unsigned hours;
      int unsigned minutes;
      int unsigned seconds;
      int unsigned day;
      int unsigned month;
      int unsigned year;
      rsp_type     expected_q[$];
      int          errors;

      function new();
         view    = VIEW_CLOCK;
         tube    = 2'd0;
         last_a  = 1'b0;
         last_b  = 1'b0;
         hours   = 13;
         minutes = 37;
         seconds = 0;
         day     = 1;
         month   = 1;
         year    = 2012;
         errors  = 0;
      endfunction

      static function logic [7:0] bcd_of(int unsigned v);
         return 8'(((v / 10) << 4) | (v % 10));
      endfunction

      function int unsigned bcd_value(logic [7:0] b);
         return int'(b[3:0]) + int'(b[7:4]) * 10;
      endfunction

      function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function void note_request(req_type r);
         rsp_type     want;
         int          enc_step;
         logic        on;
         logic        hm_a;
         logic        dm_a;
         logic        hm_b;
         logic        dm_b;
         logic        yr;
         logic        wr;
         int unsigned shown;
         case (r.mode)
            OP_PREV: view = view.prev();
            OP_NEXT: view = view.next();
            OP_LOAD: begin
               seconds = clamp(bcd_value(r.rtc_seconds), 0, 59);
               minutes = clamp(bcd_value(r.rtc_minutes), 0, 59);
               hours   = clamp(bcd_value(r.rtc_hours), 0, 23);
               day     = clamp(bcd_value({2'b00, r.rtc_day_year[5:0]}), 1, 31);
               month   = clamp(bcd_value({3'b000, r.rtc_month[4:0]}), 1, 12);
               year    = 2000 + int'(r.rtc_day_year[7:6]) + int'($signed(r.rtc_year_offset));
            end
            OP_TICK: begin
               want  = '0;
               on    = (seconds % 2) == 0;
               hm_a  = view == VIEW_CLOCK || view == SET_MINUTE || (view == SET_HOUR && on);
               dm_a  = view == VIEW_DATE || view == SET_MONTH || (view == SET_DAY && on);
               hm_b  = view == VIEW_CLOCK || view == SET_HOUR || (view == SET_MINUTE && on);
               dm_b  = view == VIEW_DATE || view == SET_DAY || (view == SET_MONTH && on);
               yr    = view == VIEW_YEAR || (view == SET_YEAR && on);
               shown = BLANK_DIGIT;
               case (tube)
                  2'd3: begin
                     if (hm_a) shown = hours / 10;
                     else if (dm_a) shown = day / 10;
                     else if (yr) shown = (year / 1000) % 10;
                  end
                  2'd2: begin
                     if (hm_a) shown = hours % 10;
                     else if (dm_a) shown = day % 10;
                     else if (yr) shown = (year / 100) % 10;
                  end
                  2'd1: begin
                     if (hm_b) shown = minutes / 10;
                     else if (dm_b) shown = month / 10;
                     else if (yr) shown = (year / 10) % 10;
                  end
                  default: begin
                     if (hm_b) shown = minutes % 10;
                     else if (dm_b) shown = month % 10;
                     else if (yr) shown = year % 10;
                  end
               endcase
               want.tube_select = tube;
               want.digit       = 4'(shown);
               want.dot         = (tube == 2'd1) &&
                  ((!on && (view == VIEW_CLOCK || view == SET_HOUR || view == SET_MINUTE)) ||
                   view == VIEW_DATE || view == SET_DAY || view == SET_MONTH);
               tube = tube + 2'd1;

               enc_step = 0;
               if (last_a && !r.enc_a && !r.enc_b && !last_b) enc_step = 1;
               else if (!last_a && r.enc_a && !r.enc_b && !last_b) enc_step = -1;
               last_a = r.enc_a;
               last_b = r.enc_b;

               wr = 1'b0;
               if (enc_step != 0) begin
                  wr = 1'b1;
                  case (view)
                     SET_HOUR: hours = enc_step > 0 ? (hours + 1) % 24 : (hours + 23) % 24;
                     SET_MINUTE: begin
                        minutes = enc_step > 0 ? (minutes + 1) % 60 : (minutes + 59) % 60;
                        seconds = 0;
                     end
                     SET_DAY: day = enc_step > 0 ? day % 31 + 1 : (day + 29) % 31 + 1;
                     SET_MONTH: month = enc_step > 0 ? month % 12 + 1 : (month + 10) % 12 + 1;
                     SET_YEAR: begin
                        if (enc_step > 0 && year < YEAR_MAX) year++;
                        else if (enc_step < 0 && year > YEAR_MIN) year--;
                     end
                     default: wr = 1'b0;
                  endcase
               end
               if (wr) begin
                  want.rtc_write      = 1'b1;
                  want.wr_seconds     = bcd_of(seconds);
                  want.wr_minutes     = bcd_of(minutes);
                  want.wr_hours       = bcd_of(hours);
                  want.wr_day_year    = bcd_of(day) | 8'((year % 4) << 6);
                  want.wr_month       = bcd_of(month);
                  want.wr_year_offset = 8'(year - year % 4 - 2000);
               end
               expected_q.push_back(want);
            end
         endcase
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("response with no request pending");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("tube_select", want.tube_select, got.tube_select);
         compare_field("digit", want.digit, got.digit);
         compare_field("dot", want.dot, got.dot);
         compare_field("rtc_write", want.rtc_write, got.rtc_write);
         compare_field("wr_seconds", want.wr_seconds, got.wr_seconds);
         compare_field("wr_minutes", want.wr_minutes, got.wr_minutes);
         compare_field("wr_hours", want.wr_hours, got.wr_hours);
         compare_field("wr_day_year", want.wr_day_year, got.wr_day_year);
         compare_field("wr_month", want.wr_month, got.wr_month);
         compare_field("wr_year_offset", want.wr_year_offset, got.wr_year_offset);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   int             idle_pct;
   int             stall_pct;
   int             quiet_cycles;
   logic           enc_gen_a;
   tick_scoreboard board;

   clock_display_and_set_controller uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_valid && req_ready) board.note_request(req_payload);
         if (rsp_valid && rsp_ready) board.check_response(rsp_payload);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_clock_display_and_set_controller failed");
            $finish;
         end
      end
   end

   function automatic req_type noise_request();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic req_type tick_req(logic a, logic b);
      req_type item;
      item       = noise_request();
      item.mode  = OP_TICK;
      item.enc_a = a;
      item.enc_b = b;
      return item;
   endfunction

   function automatic req_type view_req(op_type op);
      req_type item;
      item      = noise_request();
      item.mode = op;
      return item;
   endfunction

   function automatic req_type load_req(logic [7:0] s, logic [7:0] m, logic [7:0] h,
                                        logic [7:0] dy, logic [7:0] mo, logic [7:0] off);
      req_type item;
      item                 = noise_request();
      item.mode            = OP_LOAD;
      item.rtc_seconds     = s;
      item.rtc_minutes     = m;
      item.rtc_hours       = h;
      item.rtc_day_year    = dy;
      item.rtc_month       = mo;
      item.rtc_year_offset = off;
      return item;
   endfunction

   // mostly encoder ticks, with detents in both directions and stray levels, plus view steps and loads
   function automatic req_type random_request();
      req_type item;
      int      pick;
      item = noise_request();
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         item.mode = OP_PREV;
      end else if (pick < 20) begin
         item.mode = OP_NEXT;
      end else if (pick < 26) begin
         item.mode = OP_LOAD;
         if ($urandom_range(0, 1) == 1) begin
            item.rtc_seconds       = tick_scoreboard::bcd_of($urandom_range(0, 59));
            item.rtc_minutes       = tick_scoreboard::bcd_of($urandom_range(0, 59));
            item.rtc_hours         = tick_scoreboard::bcd_of($urandom_range(0, 23));
            item.rtc_day_year[5:0] = 6'(tick_scoreboard::bcd_of($urandom_range(1, 31)));
            item.rtc_month[4:0]    = 5'(tick_scoreboard::bcd_of($urandom_range(1, 12)));
         end
      end else begin
         item.mode = OP_TICK;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            item.enc_a = ~enc_gen_a;
            item.enc_b = 1'b0;
         end else if (pick < 85) begin
            item.enc_a = 1'b1;
            item.enc_b = 1'b1;
         end
         enc_gen_a = item.enc_a;
      end
      return item;
   endfunction

   task automatic send_request(input req_type item);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      int idle_tab[4];
      int stall_tab[4];
      idle_tab    = '{0, 49, 0, 9};
      stall_tab   = '{0, 0, 49, 9};
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      idle_pct    = 0;
      stall_pct   = 0;
      enc_gen_a   = 1'b0;
      board       = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // all tubes in clock view, encoder steps outside set modes
      send_request(tick_req(1'b0, 1'b0));
      send_request(tick_req(1'b1, 1'b0));
      send_request(tick_req(1'b0, 1'b0));
      send_request(tick_req(1'b1, 1'b1));
      send_request(view_req(OP_NEXT));
      send_request(tick_req(1'b0, 1'b1));
      send_request(view_req(OP_NEXT));
      send_request(tick_req(1'b0, 1'b0));
      // saturating load, then year up to the top and past it
      send_request(load_req(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F));
      send_request(view_req(OP_PREV));
      send_request(view_req(OP_PREV));
      send_request(view_req(OP_PREV));
      repeat (2) begin
         send_request(tick_req(1'b1, 1'b1));
         send_request(tick_req(1'b1, 1'b0));
         send_request(tick_req(1'b0, 1'b0));
      end
      // zero load, year down at the bottom
      send_request(load_req(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80));
      send_request(tick_req(1'b1, 1'b0));
      send_request(view_req(OP_NEXT));
      send_request(tick_req(1'b0, 1'b0));
      send_request(load_req(8'h59, 8'h59, 8'h23, 8'h71, 8'hF2, 8'h00));
      send_request(view_req(OP_PREV));
      send_request(view_req(OP_PREV));
      send_request(tick_req(1'b1, 1'b0));
      send_request(tick_req(1'b0, 1'b0));
      enc_gen_a = 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = idle_tab[phase];
         stall_pct = stall_tab[phase];
         repeat (PHASE_ITEMS) send_request(random_request());
      end
      req_valid <= 1'b0;

      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.expected_q.size() == 0) begin
         $display("tb_clock_display_and_set_controller passed");
      end else begin
         $display("tb_clock_display_and_set_controller failed");
      end
      $finish;
   end

endmodule
